// ===== hdl/pfr_pkg.sv =====
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared types and constants for the page frame store and refresh sequencer.
// ----------------------------------------------------------------------------
package pfr_pkg;

	typedef enum logic [1:0] {
		REQ_PIXEL   = 2'd0,
		REQ_CLEAR   = 2'd1,
		REQ_REFRESH = 2'd2,
		REQ_TICK    = 2'd3
	} req_t;

	typedef enum logic {
		SWP_IDLE = 1'b0,
		SWP_FILL = 1'b1
	} sweep_state_t;

	localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
	localparam logic [7:0] CMD_COL_LO    = 8'h00;
	localparam logic [7:0] CMD_COL_HI    = 8'h10;
	localparam int         CMD_STEPS     = 3;

	typedef struct packed {
		logic       is_data;
		logic       page_last;
		logic       frame_last;
		logic [7:0] cmd_byte;
	} tick_info_t;

endpackage

// ===== hdl/pfr_store.sv =====
// ----------------------------------------------------------------------------
// pfr_store
// Frame store RAM with one write and one registered read port, plus a fill
// engine used for the clear request and the clearing pass after reset.
// ----------------------------------------------------------------------------
module pfr_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clear_start,
	input  logic          clear_fill,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data,
	output logic          busy
);
	import pfr_pkg::*;

	logic [7:0]   mem [DEPTH];
	logic [7:0]   rd_data_q;
	sweep_state_t state_q, state_d;
	logic [AW-1:0] addr_q;
	logic [7:0]   fill_q;
	logic         sweep_last;
	logic         mem_we;
	logic [AW-1:0] mem_wa;
	logic [7:0]   mem_wd;

	assign sweep_last = (addr_q == AW'(DEPTH - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SWP_IDLE: if (clear_start) state_d = SWP_FILL;
			SWP_FILL: if (sweep_last) state_d = SWP_IDLE;
			default:  state_d = SWP_IDLE;
		endcase
	end

	always_comb begin
		busy   = 1'b0;
		mem_we = wr_en;
		mem_wa = wr_addr;
		mem_wd = wr_data;
		unique case (state_q)
			SWP_IDLE: busy = 1'b0;
			SWP_FILL: begin
				busy   = 1'b1;
				mem_we = 1'b1;
				mem_wa = addr_q;
				mem_wd = fill_q;
			end
			default: busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SWP_FILL;
			addr_q  <= '0;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == SWP_FILL) begin
				addr_q <= sweep_last ? '0 : addr_q + AW'(1);
			end
			if (state_q == SWP_IDLE && clear_start) begin
				fill_q <= {8{clear_fill}};
				addr_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (rd_en)  rd_data_q   <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

`ifndef SYNTHESIS
	a_no_wr_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !wr_en) else $error("pixel write during fill");
	a_no_rd_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !rd_en) else $error("read during fill");
	a_fill_from_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> addr_q == '0) else $error("fill not starting at zero");
`endif

endmodule

// ===== hdl/pfr_seq.sv =====
// ----------------------------------------------------------------------------
// pfr_seq
// Refresh sequencer: page and step counters, command bytes, read address.
// ----------------------------------------------------------------------------
module pfr_seq #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 8,
	parameter int AW      = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                tick,
	output logic                active,
	output pfr_pkg::tick_info_t info,
	output logic [AW-1:0]       rd_addr
);
	import pfr_pkg::*;

	localparam int PGW = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int CW  = $clog2(COLUMNS);
	localparam int SW  = $clog2(COLUMNS + CMD_STEPS);

	logic           active_q;
	logic [PGW-1:0] page_q;
	logic [SW-1:0]  step_q;
	logic [SW-1:0]  step_off;
	logic [CW-1:0]  col;
	logic           is_cmd;

	assign is_cmd   = (step_q < SW'(CMD_STEPS));
	assign step_off = step_q - SW'(CMD_STEPS);
	assign col      = step_off[CW-1:0];
	assign rd_addr  = AW'(page_q) * AW'(COLUMNS) + AW'(col);
	assign active   = active_q;

	always_comb begin
		info.is_data    = !is_cmd;
		info.page_last  = !is_cmd && (col == CW'(COLUMNS - 1));
		info.frame_last = info.page_last && (page_q == PGW'(PAGES - 1));
		priority if (step_q == SW'(0)) begin
			info.cmd_byte = CMD_PAGE_BASE | 8'(page_q);
		end else if (step_q == SW'(1)) begin
			info.cmd_byte = CMD_COL_LO;
		end else begin
			info.cmd_byte = CMD_COL_HI;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			page_q   <= '0;
			step_q   <= '0;
		end else if (start) begin
			active_q <= 1'b1;
			page_q   <= '0;
			step_q   <= '0;
		end else if (tick && active_q) begin
			if (info.page_last) begin
				step_q <= '0;
				if (info.frame_last) begin
					page_q   <= '0;
					active_q <= 1'b0;
				end else begin
					page_q <= page_q + PGW'(1);
				end
			end else begin
				step_q <= step_q + SW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_frame_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && !start && active_q && info.frame_last) |=> !active_q)
		else $error("sweep still armed after last byte");
	a_page_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && !start && active_q && info.page_last) |=> step_q == '0)
		else $error("step not reset at page end");
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (step_q == '0 && page_q == '0))
		else $error("counters not parked while idle");
`endif

endmodule

// ===== hdl/page_framebuffer_refresh.sv =====
// ----------------------------------------------------------------------------
// page_framebuffer_refresh
// Monochrome page frame store with pixel writes, fill and panel refresh output.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle for pixel writes, refresh starts and ticks while no fill runs and the output is taken;
//   a same-address write/read pair is forwarded around the RAM.
// A tick's result is registered in stage 1 and then in the output register.
// A clear holds in_ready low while the fill writes all PAGES*COLUMNS bytes (one RAM write a cycle).
// Reset: asynchronous; the same fill pass then writes 0x00 to all
//   PAGES*COLUMNS bytes before the first word is accepted.
module page_framebuffer_refresh #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  logic [7:0] pix_col,
	input  logic [7:0] pix_row,
	input  logic       pix_color,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       is_data,
	output logic       page_last,
	output logic       frame_last
);
	import pfr_pkg::*;

	localparam int DEPTH = COLUMNS * PAGES;
	localparam int AW    = $clog2(DEPTH);

	logic          accept;
	logic          busy;
	logic          seq_active;
	tick_info_t    seq_info;
	logic [AW-1:0] seq_addr;
	logic          in_bounds;
	logic [12:0]   pix_addr_w;
	logic [AW-1:0] pix_addr;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	logic [7:0]    rd_eff;
	logic          wr_en;
	logic [7:0]    wr_data;
	logic          s1_adv;

	logic          valid_s1;
	logic          wr_s1;
	logic          res_s1;
	tick_info_t    info_s1;
	logic [AW-1:0] addr_s1;
	logic [7:0]    mask_s1;
	logic          color_s1;
	logic          fwd_hit_s1;
	logic [7:0]    fwd_data_s1;

	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          is_data_q;
	logic          page_last_q;
	logic          frame_last_q;

	assign accept = in_valid && in_ready;
	assign s1_adv = !(valid_s1 && res_s1) || !out_valid_q || out_ready;
	assign in_ready = !busy && s1_adv;

	assign in_bounds  = ({1'b0, pix_col} < 9'(COLUMNS)) && ({1'b0, pix_row} < 9'(8 * PAGES));
	assign pix_addr_w = 13'(pix_row[7:3]) * 13'(COLUMNS) + 13'(pix_col);
	assign pix_addr   = pix_addr_w[AW-1:0];
	assign rd_addr    = (req_type == REQ_TICK) ? seq_addr : pix_addr;

	assign rd_eff  = fwd_hit_s1 ? fwd_data_s1 : rd_data;
	assign wr_en   = valid_s1 && wr_s1;
	assign wr_data = color_s1 ? (rd_eff | mask_s1) : (rd_eff & ~mask_s1);

	pfr_seq #(
		.COLUMNS(COLUMNS),
		.PAGES  (PAGES),
		.AW     (AW)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && req_type == REQ_REFRESH),
		.tick   (accept && req_type == REQ_TICK),
		.active (seq_active),
		.info   (seq_info),
		.rd_addr(seq_addr)
	);

	pfr_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear_start(accept && req_type == REQ_CLEAR),
		.clear_fill (pix_color),
		.wr_en      (wr_en),
		.wr_addr    (addr_s1),
		.wr_data    (wr_data),
		.rd_en      (accept),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.busy       (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wr_s1       <= (req_type == REQ_PIXEL) && in_bounds;
			res_s1      <= (req_type == REQ_TICK) && seq_active;
			info_s1     <= seq_info;
			addr_s1     <= pix_addr;
			mask_s1     <= 8'(1) << pix_row[2:0];
			color_s1    <= pix_color;
			fwd_hit_s1  <= wr_en && (addr_s1 == rd_addr);
			fwd_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && res_s1 && s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && res_s1 && s1_adv) begin
			out_byte_q   <= info_s1.is_data ? rd_eff : info_s1.cmd_byte;
			is_data_q    <= info_s1.is_data;
			page_last_q  <= info_s1.page_last;
			frame_last_q <= info_s1.frame_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign is_data    = is_data_q;
	assign page_last  = page_last_q;
	assign frame_last = frame_last_q;

`ifndef SYNTHESIS
	a_no_write_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res_s1) |-> !wr_s1) else $error("tick marked as write");
	a_hold_while_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res_s1 && !s1_adv) |-> !in_ready)
		else $error("input taken while stage blocked");
	a_fill_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready) else $error("input taken during fill");
`endif

endmodule
